// ----- rtl/core/pbpm_pkg.sv -----
package pbpm_pkg;

    localparam logic [3:0] KIND_INSERT  = 4'd0;
    localparam logic [3:0] KIND_READ    = 4'd1;
    localparam logic [3:0] KIND_REMOVE  = 4'd2;
    localparam logic [3:0] KIND_DELETE  = 4'd3;
    localparam logic [3:0] KIND_CLEAR   = 4'd4;
    localparam logic [3:0] KIND_SUM     = 4'd5;
    localparam logic [3:0] KIND_LENGTH  = 4'd6;
    localparam logic [3:0] KIND_RESERVE = 4'd7;
    localparam logic [3:0] KIND_USE     = 4'd8;
    localparam logic [3:0] KIND_RELEASE = 4'd9;

    // offset or count meaning "last entry" / "through the end"
    localparam logic [15:0] LAST_MARK = 16'hFFFF;

    typedef struct packed {
        logic [3:0]  kind;
        logic [4:0]  partition;
        logic [15:0] position;
        logic [15:0] extent;
        logic [11:0] byte_size;
        logic [23:0] frame_address;
        logic [7:0]  file_number;
        logic [7:0]  channel_number;
        logic [7:0]  sub_mode;
        logic [7:0]  coding_information;
    } in_item_t;

    typedef struct packed {
        logic        ok;
        logic [7:0]  slot;
        logic [11:0] entry_size;
        logic [23:0] entry_frame;
        logic [7:0]  entry_file;
        logic [7:0]  entry_channel;
        logic [7:0]  entry_submode;
        logic [7:0]  entry_coding;
        logic [19:0] value;
        logic [7:0]  free_available;
    } out_item_t;

    // span of list entries an operation walks to and then visits
    typedef struct packed {
        logic        run;
        logic [15:0] start;
        logic [15:0] count;
        logic        tail_fix;
    } range_t;

endpackage

// ----- rtl/core/partitioned_buffer_pool_manager.sv -----
// Items pass one at a time: reserve, use, release, length and rejected items go straight to the
// finishing state; insert first links the slot in; read walks to the entry; size sum walks and
// then adds up n entries; remove, delete and clear walk, unlink n entries and fix the links,
// with n the entries unlinked or summed. A held result stalls input.
// Reset: synchronous, active low; then a pass over every slot chains the free list in the
// link RAM, during which no item is accepted.
module partitioned_buffer_pool_manager #(
    parameter int NUM_BUFFERS    = 200,
    parameter int NUM_PARTITIONS = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pbpm_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output pbpm_pkg::out_item_t m_item
);

    localparam int SLOT_W = $clog2(NUM_BUFFERS);
    localparam int CNT_W  = $clog2(NUM_BUFFERS + 1);
    localparam int PIDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;

    typedef enum logic [7:0] {
        ST_INIT   = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_INSERT = 8'b0000_0100,
        ST_WALK   = 8'b0000_1000,
        ST_UNLINK = 8'b0001_0000,
        ST_FIX    = 8'b0010_0000,
        ST_SUM    = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    state_t              state_reg;
    logic [SLOT_W-1:0]   init_idx_reg;
    logic [SLOT_W-1:0]   head_reg [NUM_PARTITIONS];
    logic [SLOT_W-1:0]   tail_reg [NUM_PARTITIONS];
    logic [CNT_W-1:0]    len_reg  [NUM_PARTITIONS];
    logic [SLOT_W-1:0]   free_head_reg;
    logic [CNT_W-1:0]    free_total_reg;
    logic [CNT_W-1:0]    reserved_reg;
    logic [3:0]          op_reg;
    logic [PIDX_W-1:0]   pidx_reg;
    logic [SLOT_W-1:0]   cur_reg;
    logic [SLOT_W-1:0]   cur_next;
    logic [SLOT_W-1:0]   prev_reg;
    logic                has_prev_reg;
    logic                tail_fix_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    n_reg;
    pbpm_pkg::out_item_t res_reg;
    pbpm_pkg::out_item_t m_item_reg;
    logic                m_valid_reg;

    // item decode
    logic              pvalid;
    logic [PIDX_W-1:0] pidx;
    logic [CNT_W-1:0]  in_len;
    logic              bad_item;
    pbpm_pkg::range_t  rng;

    // RAM ports
    logic              link_we;
    logic [SLOT_W-1:0] link_waddr;
    logic [SLOT_W-1:0] link_wdata;
    logic [SLOT_W-1:0] link_rdata;
    logic              desc_we;
    logic [35:0]       sf_rdata;
    logic [31:0]       sh_rdata;
    logic [7:0]        free_avail;

    assign pvalid   = 32'(s_item.partition) < NUM_PARTITIONS;
    assign pidx     = PIDX_W'(s_item.partition);
    assign in_len   = pvalid ? len_reg[pidx] : '0;
    assign bad_item = (s_item.kind > pbpm_pkg::KIND_RELEASE)
                   || (s_item.kind <= pbpm_pkg::KIND_LENGTH && !pvalid);

    pbpm_range u_range (
        .kind     (s_item.kind),
        .position (s_item.position),
        .extent   (s_item.extent),
        .len      (16'(in_len)),
        .rng      (rng)
    );

    // The link RAM is always read at the slot the walker holds next, so its data in any
    // cycle is the successor of cur_reg.
    always_comb begin
        cur_next = cur_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_item.kind == pbpm_pkg::KIND_INSERT) begin
                        cur_next = free_head_reg;
                    end else if (pvalid) begin
                        cur_next = head_reg[pidx];
                    end
                end
            end
            ST_WALK: begin
                if (cnt_reg != '0) begin
                    cur_next = link_rdata;
                end
            end
            ST_UNLINK, ST_SUM: begin
                cur_next = link_rdata;
            end
            default: begin
                cur_next = cur_reg;
            end
        endcase
    end

    always_comb begin
        link_we    = 1'b0;
        link_waddr = cur_reg;
        link_wdata = free_head_reg;
        unique case (state_reg)
            ST_INIT: begin
                link_we    = 1'b1;
                link_waddr = init_idx_reg;
                link_wdata = (init_idx_reg == SLOT_W'(NUM_BUFFERS - 1)) ? '0
                           : init_idx_reg + SLOT_W'(1);
            end
            ST_INSERT: begin
                // append behind the current tail
                link_we    = len_reg[pidx_reg] != '0;
                link_waddr = tail_reg[pidx_reg];
                link_wdata = cur_reg;
            end
            ST_UNLINK: begin
                // push the removed slot onto the free list
                link_we    = 1'b1;
                link_waddr = cur_reg;
                link_wdata = free_head_reg;
            end
            ST_FIX: begin
                // bridge the gap over the removed span
                link_we    = has_prev_reg;
                link_waddr = prev_reg;
                link_wdata = cur_reg;
            end
            default: begin
                link_we = 1'b0;
            end
        endcase
    end

    assign desc_we = (state_reg == ST_IDLE) && s_valid && !bad_item
                  && (s_item.kind == pbpm_pkg::KIND_INSERT) && (free_total_reg != '0);

    pbpm_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_BUFFERS)) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (cur_next),
        .rdata (link_rdata)
    );

    pbpm_ram #(.WIDTH(36), .DEPTH(NUM_BUFFERS)) u_size_frame_ram (
        .aclk  (aclk),
        .we    (desc_we),
        .waddr (free_head_reg),
        .wdata ({s_item.byte_size, s_item.frame_address}),
        .raddr (cur_next),
        .rdata (sf_rdata)
    );

    pbpm_ram #(.WIDTH(32), .DEPTH(NUM_BUFFERS)) u_subheader_ram (
        .aclk  (aclk),
        .we    (desc_we),
        .waddr (free_head_reg),
        .wdata ({s_item.file_number, s_item.channel_number,
                 s_item.sub_mode, s_item.coding_information}),
        .raddr (cur_next),
        .rdata (sh_rdata)
    );

    assign free_avail = (free_total_reg > reserved_reg) ? 8'(free_total_reg - reserved_reg)
                      : 8'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_INIT;
            init_idx_reg   <= '0;
            free_head_reg  <= '0;
            free_total_reg <= CNT_W'(NUM_BUFFERS);
            reserved_reg   <= '0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < NUM_PARTITIONS; i++) begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                len_reg[i]  <= '0;
            end
        end else begin
            cur_reg <= cur_next;
            // raise on a finished item, drop once the receiver takes it
            if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_INIT: begin
                    init_idx_reg <= init_idx_reg + SLOT_W'(1);
                    if (init_idx_reg == SLOT_W'(NUM_BUFFERS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg       <= s_item.kind;
                        pidx_reg     <= pidx;
                        res_reg      <= '0;
                        prev_reg     <= '0;
                        has_prev_reg <= 1'b0;
                        tail_fix_reg <= rng.tail_fix;
                        n_reg        <= CNT_W'(rng.count);
                        cnt_reg      <= CNT_W'(rng.start);
                        state_reg    <= ST_DONE;
                        if (!bad_item) begin
                            case (s_item.kind) inside
                                pbpm_pkg::KIND_INSERT: begin
                                    if (free_total_reg != '0) begin
                                        res_reg.ok            <= 1'b1;
                                        res_reg.slot          <= 8'(free_head_reg);
                                        res_reg.entry_size    <= s_item.byte_size;
                                        res_reg.entry_frame   <= s_item.frame_address;
                                        res_reg.entry_file    <= s_item.file_number;
                                        res_reg.entry_channel <= s_item.channel_number;
                                        res_reg.entry_submode <= s_item.sub_mode;
                                        res_reg.entry_coding  <= s_item.coding_information;
                                        state_reg             <= ST_INSERT;
                                    end
                                end
                                pbpm_pkg::KIND_READ, pbpm_pkg::KIND_REMOVE: begin
                                    if (rng.run) begin
                                        res_reg.ok <= 1'b1;
                                        state_reg  <= ST_WALK;
                                    end
                                end
                                pbpm_pkg::KIND_DELETE, pbpm_pkg::KIND_CLEAR,
                                pbpm_pkg::KIND_SUM: begin
                                    res_reg.ok <= 1'b1;
                                    if (rng.run) begin
                                        state_reg <= ST_WALK;
                                    end
                                end
                                pbpm_pkg::KIND_LENGTH: begin
                                    res_reg.ok    <= 1'b1;
                                    res_reg.value <= 20'(in_len);
                                end
                                pbpm_pkg::KIND_RESERVE: begin
                                    if (s_item.extent != 16'd0
                                        && s_item.extent <= 16'(free_total_reg)) begin
                                        reserved_reg <= CNT_W'(s_item.extent);
                                        res_reg.ok   <= 1'b1;
                                    end
                                end
                                pbpm_pkg::KIND_USE: begin
                                    if (s_item.extent <= 16'(reserved_reg)) begin
                                        reserved_reg <= reserved_reg - CNT_W'(s_item.extent);
                                        res_reg.ok   <= 1'b1;
                                    end
                                end
                                pbpm_pkg::KIND_RELEASE: begin
                                    reserved_reg <= '0;
                                    res_reg.ok   <= 1'b1;
                                end
                                default: begin
                                    res_reg.ok <= 1'b0;
                                end
                            endcase
                        end
                    end
                end
                ST_INSERT: begin
                    // link data here is the successor of the slot just taken
                    free_head_reg  <= link_rdata;
                    free_total_reg <= free_total_reg - CNT_W'(1);
                    if (len_reg[pidx_reg] == '0) begin
                        head_reg[pidx_reg] <= cur_reg;
                    end
                    tail_reg[pidx_reg] <= cur_reg;
                    len_reg[pidx_reg]  <= len_reg[pidx_reg] + CNT_W'(1);
                    state_reg          <= ST_DONE;
                end
                ST_WALK: begin
                    if (cnt_reg != '0) begin
                        // advance one entry, remembering the one behind
                        prev_reg     <= cur_reg;
                        has_prev_reg <= 1'b1;
                        cnt_reg      <= cnt_reg - CNT_W'(1);
                    end else begin
                        cnt_reg <= n_reg;
                        case (op_reg) inside
                            pbpm_pkg::KIND_READ, pbpm_pkg::KIND_REMOVE: begin
                                res_reg.slot          <= 8'(cur_reg);
                                res_reg.entry_size    <= sf_rdata[35:24];
                                res_reg.entry_frame   <= sf_rdata[23:0];
                                res_reg.entry_file    <= sh_rdata[31:24];
                                res_reg.entry_channel <= sh_rdata[23:16];
                                res_reg.entry_submode <= sh_rdata[15:8];
                                res_reg.entry_coding  <= sh_rdata[7:0];
                                if (op_reg == pbpm_pkg::KIND_REMOVE) begin
                                    res_reg.value <= 20'd1;
                                    state_reg     <= ST_UNLINK;
                                end else begin
                                    state_reg <= ST_DONE;
                                end
                            end
                            pbpm_pkg::KIND_DELETE, pbpm_pkg::KIND_CLEAR: begin
                                res_reg.value <= 20'(n_reg);
                                state_reg     <= ST_UNLINK;
                            end
                            pbpm_pkg::KIND_SUM: begin
                                state_reg <= ST_SUM;
                            end
                            default: begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_UNLINK: begin
                    free_head_reg <= cur_reg;
                    cnt_reg       <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1)) begin
                        state_reg <= ST_FIX;
                    end
                end
                ST_FIX: begin
                    if (!has_prev_reg) begin
                        head_reg[pidx_reg] <= cur_reg;
                    end
                    if (tail_fix_reg) begin
                        tail_reg[pidx_reg] <= prev_reg;
                    end
                    len_reg[pidx_reg] <= len_reg[pidx_reg] - n_reg;
                    // an emptied partition drops back to zero head and tail
                    if (len_reg[pidx_reg] == n_reg) begin
                        head_reg[pidx_reg] <= '0;
                        tail_reg[pidx_reg] <= '0;
                    end
                    free_total_reg <= free_total_reg + n_reg;
                    state_reg      <= ST_DONE;
                end
                ST_SUM: begin
                    res_reg.value <= res_reg.value + 20'(sf_rdata[35:24]);
                    cnt_reg       <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1)) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_item_reg <= {res_reg[$bits(pbpm_pkg::out_item_t)-1:8], free_avail};
                        state_reg  <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // free count can never exceed the pool
    assert property (@(posedge aclk) disable iff (!aresetn)
        free_total_reg <= CNT_W'(NUM_BUFFERS))
        else $error("free count above pool size");

    // a result only appears straight out of the finishing state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside finish");

    // unlink and sum always have entries left to visit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UNLINK || state_reg == ST_SUM) |-> cnt_reg != '0)
        else $error("span counter ran out");

endmodule

// ----- rtl/core/pbpm_ram.sv -----
module pbpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 200
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/pbpm_range.sv -----
module pbpm_range (
    input  logic [3:0]       kind,
    input  logic [15:0]      position,
    input  logic [15:0]      extent,
    input  logic [15:0]      len,
    output pbpm_pkg::range_t rng
);

    always_comb begin
        logic [15:0] lm1;
        logic [15:0] a;
        logic [15:0] b;
        logic [16:0] last;
        lm1  = len - 16'd1;
        a    = '0;
        b    = '0;
        last = '0;
        rng  = '0;
        case (kind) inside
            pbpm_pkg::KIND_READ, pbpm_pkg::KIND_REMOVE: begin
                rng.run   = position < len;
                rng.start = position;
                rng.count = 16'd1;
            end
            pbpm_pkg::KIND_DELETE: begin
                rng.run = (len != 16'd0) && (extent != 16'd0);
                a = (position == pbpm_pkg::LAST_MARK || position >= len) ? lm1 : position;
                if (extent == pbpm_pkg::LAST_MARK) begin
                    last = {1'b0, lm1};
                end else begin
                    last = {1'b0, a} + {1'b0, extent} - 17'd1;
                end
                if (last > {1'b0, lm1}) begin
                    last = {1'b0, lm1};
                end
                rng.start = a;
                rng.count = last[15:0] - a + 16'd1;
            end
            pbpm_pkg::KIND_CLEAR: begin
                rng.run   = len != 16'd0;
                rng.count = len;
            end
            pbpm_pkg::KIND_SUM: begin
                a = (position < len) ? position : lm1;
                b = (extent < len) ? extent : lm1;
                rng.run   = (len != 16'd0) && (a <= b);
                rng.start = a;
                rng.count = b - a + 16'd1;
            end
            default: begin
                rng = '0;
            end
        endcase
        rng.tail_fix = ({1'b0, rng.start} + {1'b0, rng.count}) == {1'b0, len};
    end

endmodule
